>>> rtl/packet_sequence_double_buffer_placer_unit_assert.svh
// Assertion macros for the packet placer.
// Each use expands to one labeled concurrent assertion clocked on clk,
// disabled while arst_n is low.
`ifndef PACKET_SEQUENCE_DOUBLE_BUFFER_PLACER_UNIT_ASSERT_SVH
`define PACKET_SEQUENCE_DOUBLE_BUFFER_PLACER_UNIT_ASSERT_SVH

// same-cycle implication
`define PSDBP_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("placer check failed");

// next-cycle implication
`define PSDBP_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("placer check failed");

`endif

>>> rtl/psdbp_pkg.sv
package psdbp_pkg;

	// window geometry
	localparam int SLOTS        = 4096;
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int CNT_W        = SLOT_W + 1;

	// sequence extraction
	localparam int RAW_W        = 64;
	localparam int SEQ_SHIFT    = 11;
	localparam int SEQ_W        = RAW_W - SEQ_SHIFT;
	localparam int DIST_W       = SEQ_W - SLOT_W;

	// overrun block ends allowed per item before the packet is dropped
	localparam int MAX_OVR_ENDS = 14;

	// result index within one item (up to 16 results)
	localparam int IDX_W        = 4;
	localparam int TOT_W        = IDX_W + 1;

	// configuration
	localparam int START_W      = 20;
	localparam int IGN_W        = 16;
	localparam int CFG_W        = START_W;
	localparam logic [START_W-1:0] START_LIMIT_RST  = 20'd10000;
	localparam logic [IGN_W-1:0]   IGNORE_LIMIT_RST = 16'd4095;

	// offsets above this in the next window end the block
	localparam logic [SLOT_W-1:0] HALF_LIM = SLOT_W'(SLOTS - 1 - SLOTS / 2);

	typedef enum logic [2:0] {
		KIND_CUR   = 3'd0,
		KIND_NXT   = 3'd1,
		KIND_UNDER = 3'd2,
		KIND_IGN   = 3'd3,
		KIND_END   = 3'd4,
		KIND_OVR   = 3'd5
	} kind_t;

	typedef enum logic {
		CFG_START_LIMIT  = 1'b0,
		CFG_IGNORE_LIMIT = 1'b1
	} cfg_reg_t;

	// result list of one item: n_pre block ends, optional middle result,
	// optional trailing block end
	typedef struct packed {
		logic [IDX_W-1:0]  n_pre;
		logic [CNT_W-1:0]  fill_a;
		logic [CNT_W-1:0]  fill_b;
		logic              mid_vld;
		kind_t             mid_kind;
		logic [SLOT_W-1:0] mid_slot;
		logic              tail_vld;
		logic              tail_part;
		logic [CNT_W-1:0]  tail_fill;
		logic [TOT_W-1:0]  tot;
	} plan_t;

	// next window base is always base + SLOTS
	typedef struct packed {
		logic             started;
		logic [SEQ_W-1:0] base;
		logic [CNT_W-1:0] cur_cnt;
		logic [CNT_W-1:0] nxt_cnt;
		logic [IGN_W-1:0] ign_cnt;
	} state_t;

endpackage

>>> rtl/packet_sequence_double_buffer_placer_unit.sv
// Channel   Signals                                       Direction
// item      item_valid, item_stall, mode, raw_sequence    in
// result    result_valid, result_stall, kind, slot,       out
//           fill_count, dropped_count, partial, last
// config    cfg_valid, cfg_ready, cfg_index, cfg_data     in
//
// One result is loaded per cycle unless result_stall holds: a single-result
// item is taken each cycle; an item of N results (N <= 16) is held for N loads.
// The decision is formed from the item register and the window state in one pass
// and lands in the result register; the window state commits with the last result.
// arst_n clears window state and valid flags and loads the default limits.
// result_stall holds the result register; the item register refills in the same
// cycle its last result is loaded.

`include "packet_sequence_double_buffer_placer_unit_assert.svh"

module packet_sequence_double_buffer_placer_unit
	import psdbp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               mode,
	input  logic [RAW_W-1:0]   raw_sequence,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic [2:0]         kind,
	output logic [SLOT_W-1:0]  slot,
	output logic [CNT_W-1:0]   fill_count,
	output logic [CNT_W-1:0]   dropped_count,
	output logic               partial,
	output logic               last,
	// configuration channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	// item register
	logic              vld_s1;
	logic              mode_s1;
	logic [SEQ_W-1:0]  seq_s1;
	logic [IDX_W-1:0]  idx_q;

	// window state and limits
	state_t            st_q;
	state_t            st_d;
	logic [START_W-1:0] start_lim_q;
	logic [IGN_W-1:0]  ign_lim_q;

	// result register
	logic              res_vld_q;
	kind_t             kind_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  drop_q;
	logic              part_q;
	logic              last_q;

	// decision
	plan_t             plan;
	logic              start_ok;
	logic [SEQ_W-1:0]  eff_base;
	logic [CNT_W-1:0]  eff_cc;
	logic [CNT_W-1:0]  eff_nc;
	logic [SEQ_W:0]    diff;
	logic              is_under;
	logic [SEQ_W-1:0]  off;
	logic [SLOT_W-1:0] noff;
	logic [DIST_W-1:0] win_dist;
	logic              d_zero;
	logic              d_near;
	logic [IDX_W-1:0]  k;
	logic [CNT_W-1:0]  cc_k;
	logic [CNT_W-1:0]  nc_k;
	logic [CNT_W-1:0]  nc_inc;
	logic [CNT_W-1:0]  cc_inc;
	logic [SEQ_W-1:0]  seq_m_noff;
	logic [SEQ_W-1:0]  base_nxt;
	logic [SEQ_W-1:0]  base_ovr;

	// result select
	kind_t             r_kind;
	logic [SLOT_W-1:0] r_slot;
	logic [CNT_W-1:0]  r_fill;
	logic [CNT_W-1:0]  r_drop;
	logic              r_part;
	logic              r_last;

	// handshakes
	logic              ld;
	logic              acc;

	assign ld         = vld_s1 & (~res_vld_q | ~result_stall);
	assign item_stall = vld_s1 & ~(ld & r_last);
	assign acc        = item_valid & ~item_stall;
	assign cfg_ready  = 1'b1;

	// effective window: a starting packet opens the window at its own sequence
	assign start_ok = (seq_s1 < SEQ_W'(start_lim_q));
	assign eff_base = st_q.started ? st_q.base : seq_s1;
	assign eff_cc   = st_q.started ? st_q.cur_cnt : '0;
	assign eff_nc   = st_q.started ? st_q.nxt_cnt : '0;

	// distance from current window base, in whole windows
	assign diff     = {1'b0, seq_s1} - {1'b0, eff_base};
	assign is_under = diff[SEQ_W];
	assign off      = diff[SEQ_W-1:0];
	assign noff     = off[SLOT_W-1:0];
	assign win_dist = off[SEQ_W-1:SLOT_W];
	assign d_zero   = (win_dist == '0);
	assign d_near   = ~d_zero && (win_dist <= DIST_W'(MAX_OVR_ENDS + 1));

	// k block ends before placing into next; counts roll through the swaps
	assign k      = win_dist[IDX_W-1:0] - IDX_W'(1);
	assign cc_k   = (k == '0) ? eff_cc : ((k == IDX_W'(1)) ? eff_nc : '0);
	assign nc_k   = (k == '0) ? eff_nc : '0;
	assign nc_inc = (nc_k < CNT_W'(SLOTS)) ? nc_k + CNT_W'(1) : nc_k;
	assign cc_inc = eff_cc + CNT_W'(1);

	// window bases after swaps
	assign seq_m_noff = seq_s1 - SEQ_W'(noff);
	assign base_nxt   = st_q.base + SEQ_W'(SLOTS);
	assign base_ovr   = st_q.base + SEQ_W'(MAX_OVR_ENDS * SLOTS);

	// plan of results and next window state
	always_comb begin
		plan          = '0;
		plan.fill_a   = eff_cc;
		plan.fill_b   = eff_nc;
		plan.tail_fill = eff_cc;
		st_d          = st_q;
		if (mode_s1) begin
			// timeout: partial block end
			plan.tail_vld  = 1'b1;
			plan.tail_part = 1'b1;
			plan.tail_fill = st_q.cur_cnt;
			st_d.base      = base_nxt;
			st_d.cur_cnt   = st_q.nxt_cnt;
			st_d.nxt_cnt   = '0;
			st_d.ign_cnt   = '0;
		end else if (!st_q.started && !start_ok) begin
			// not started yet: ignore, maybe end an empty block
			plan.mid_vld  = 1'b1;
			plan.mid_kind = KIND_IGN;
			if (st_q.ign_cnt >= ign_lim_q) begin
				plan.tail_vld  = 1'b1;
				plan.tail_fill = st_q.cur_cnt;
				st_d.base      = base_nxt;
				st_d.cur_cnt   = st_q.nxt_cnt;
				st_d.nxt_cnt   = '0;
				st_d.ign_cnt   = '0;
			end else begin
				st_d.ign_cnt = st_q.ign_cnt + IGN_W'(1);
			end
		end else begin
			st_d.started = 1'b1;
			st_d.base    = eff_base;
			st_d.cur_cnt = eff_cc;
			st_d.nxt_cnt = eff_nc;
			plan.mid_vld = 1'b1;
			if (is_under) begin
				plan.mid_kind = KIND_UNDER;
			end else if (d_zero) begin
				// current window, end at once when full
				plan.mid_kind = KIND_CUR;
				plan.mid_slot = noff;
				if (cc_inc >= CNT_W'(SLOTS)) begin
					plan.tail_vld  = 1'b1;
					plan.tail_fill = cc_inc;
					st_d.base      = base_nxt;
					st_d.cur_cnt   = eff_nc;
					st_d.nxt_cnt   = '0;
					st_d.ign_cnt   = '0;
				end else begin
					st_d.cur_cnt = cc_inc;
				end
			end else if (d_near) begin
				// k swaps, then next window; late half ends the block
				plan.n_pre    = k;
				plan.mid_kind = KIND_NXT;
				plan.mid_slot = noff;
				if (k != '0) begin
					st_d.ign_cnt = '0;
				end
				if (noff > HALF_LIM) begin
					plan.tail_vld  = 1'b1;
					plan.tail_fill = cc_k;
					st_d.base      = seq_m_noff;
					st_d.cur_cnt   = nc_inc;
					st_d.nxt_cnt   = '0;
					st_d.ign_cnt   = '0;
				end else begin
					st_d.base    = seq_m_noff - SEQ_W'(SLOTS);
					st_d.cur_cnt = cc_k;
					st_d.nxt_cnt = nc_inc;
				end
			end else begin
				// too far ahead: capped swaps, then drop
				plan.n_pre    = IDX_W'(MAX_OVR_ENDS);
				plan.mid_kind = KIND_OVR;
				st_d.base     = base_ovr;
				st_d.cur_cnt  = '0;
				st_d.nxt_cnt  = '0;
				st_d.ign_cnt  = '0;
			end
		end
		plan.tot = TOT_W'(plan.n_pre) + TOT_W'(plan.mid_vld) + TOT_W'(plan.tail_vld);
	end

	// pick the result at idx_q
	always_comb begin
		r_kind = KIND_END;
		r_slot = '0;
		r_fill = '0;
		r_part = 1'b0;
		if (idx_q < plan.n_pre) begin
			if (idx_q == '0) begin
				r_fill = plan.fill_a;
			end else if (idx_q == IDX_W'(1)) begin
				r_fill = plan.fill_b;
			end
		end else if (idx_q == plan.n_pre && plan.mid_vld) begin
			r_kind = plan.mid_kind;
			r_slot = plan.mid_slot;
		end else begin
			r_fill = plan.tail_fill;
			r_part = plan.tail_part;
		end
		if (r_kind != KIND_END || r_part || r_fill == '0 || r_fill >= CNT_W'(SLOTS)) begin
			r_drop = '0;
		end else begin
			r_drop = CNT_W'(SLOTS) - r_fill;
		end
		r_last = ((TOT_W'(idx_q) + TOT_W'(1)) == plan.tot);
	end

	// item register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (ld && r_last) begin
				vld_s1 <= 1'b0;
			end
			if (ld) begin
				idx_q <= r_last ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1 <= mode;
			seq_s1  <= raw_sequence[RAW_W-1:SEQ_SHIFT];
		end
	end

	// window state commits with the last result of the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (ld && r_last) begin
			st_q <= st_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_lim_q <= START_LIMIT_RST;
			ign_lim_q   <= IGNORE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_LIMIT:  start_lim_q <= cfg_data[START_W-1:0];
				CFG_IGNORE_LIMIT: ign_lim_q   <= cfg_data[IGN_W-1:0];
				default: ;
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (ld) begin
			res_vld_q <= 1'b1;
		end else if (!result_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ld) begin
			kind_q <= r_kind;
			slot_q <= r_slot;
			fill_q <= r_fill;
			drop_q <= r_drop;
			part_q <= r_part;
			last_q <= r_last;
		end
	end

	assign result_valid  = res_vld_q;
	assign kind          = kind_q;
	assign slot          = slot_q;
	assign fill_count    = fill_q;
	assign dropped_count = drop_q;
	assign partial       = part_q;
	assign last          = last_q;

	// checks
	`PSDBP_ASSERT_IMP(a_idx_in_plan, vld_s1, TOT_W'(idx_q) < plan.tot)
	`PSDBP_ASSERT_NXT(a_idx_rewind, ld && r_last, idx_q == '0)
	`PSDBP_ASSERT_NXT(a_item_frees, ld && r_last && !acc, !vld_s1)
	`PSDBP_ASSERT_IMP(a_cnt_bound, 1'b1, st_q.cur_cnt <= CNT_W'(SLOTS) && st_q.nxt_cnt <= CNT_W'(SLOTS))
	`PSDBP_ASSERT_IMP(a_started_sticky, 1'b1, !$fell(st_q.started))

endmodule
